[rtl/ffc_pkg.sv]
package ffc_pkg;

	typedef enum logic [1:0] {
		CMD_H2S = 2'd0,
		CMD_S2H = 2'd1,
		CMD_B2S = 2'd2,
		CMD_S2B = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		HC_ZERO,
		HC_SUB,
		HC_SPECIAL,
		HC_NORM
	} hclass_t;

	typedef enum logic [2:0] {
		NC_NAN,
		NC_INF,
		NC_NORM,
		NC_SUB,
		NC_ZERO
	} nclass_t;

	localparam int unsigned OP_W = 32;
	localparam int unsigned IN_TDATA_W = 40;

	localparam logic [15:0] EXP16_ALL = 16'h7c00;
	localparam logic [9:0] QUIET16 = 10'h200;
	localparam logic [15:0] QUIET_BF = 16'h0040;
	localparam logic [7:0] REBIAS = 8'd112;
	localparam logic [7:0] EXP32_ALL = 8'hff;
	localparam logic [7:0] HALF_OVF_EXP = 8'd142;
	localparam logic [7:0] HALF_NORM_EXP = 8'd113;
	localparam logic [7:0] HALF_SUB_EXP = 8'd102;
	localparam logic [7:0] SUB_SHIFT_BASE = 8'd125;
	localparam logic [4:0] SUB_SHIFT_MIN = 5'd13;

	typedef struct packed {
		cmd_t cmd;
		logic [OP_W-1:0] op;
		hclass_t hclass;
		logic [3:0] lz;
		nclass_t nclass;
		logic [4:0] sh_m1;
	} dec_t;

	typedef struct packed {
		cmd_t cmd;
		logic [OP_W-1:0] base;
		logic inc;
	} rnd_t;

	typedef struct packed {
		cmd_t cmd;
		logic [OP_W-1:0] result;
	} res_t;

endpackage

[rtl/float_format_converter.sv]
// Floating-point format converter between binary16, binary32 and bfloat16.
// Each transfer on the slave channel carries a command and a 32-bit operand;
// each transfer on the master channel carries one converted bit pattern.
// Sixteen-bit sources are taken from the low half of the operand, and
// sixteen-bit results sit in the low half of the result with the rest zero.
// The block is a three-stage pipeline: classification, then alignment and
// the rounding decision, then the rounding increment and the output
// register. A result passes through the classification, rounding and output
// registers before it reaches the master channel, and one transfer per cycle
// is sustained in both directions while the receiver keeps tready high.
// When the receiver holds tready low with a result waiting, the
// whole pipeline holds and s_axis_tready drops; items already in flight are
// kept and none is lost or repeated. s_axis_tready is high whenever the
// output register is empty, even while earlier items are still in flight.
// Reset clears the valid bits of every stage, so the master channel is idle
// and the block is ready straight after reset.
module float_format_converter (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// [1:0] command, [33:2] operand_bits, [39:34] zero
	input  logic [ffc_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// [31:0] result_bits
	output logic [ffc_pkg::OP_W-1:0] m_axis_tdata
);
	import ffc_pkg::*;

	logic en;
	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	dec_t dec_s1;
	rnd_t rnd_s2;
	res_t res_s3;
	cmd_t in_cmd;

	assign en = !valid_s3 || m_axis_tready;
	assign s_axis_tready = en;
	assign in_cmd = cmd_t'(s_axis_tdata[1:0]);

	ffc_decode u_decode (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(s_axis_tvalid),
		.in_cmd(in_cmd),
		.in_op(s_axis_tdata[OP_W+1:2]),
		.valid_s1(valid_s1),
		.dec_s1(dec_s1)
	);

	ffc_round u_round (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.valid_s1(valid_s1),
		.dec_s1(dec_s1),
		.valid_s2(valid_s2),
		.rnd_s2(rnd_s2)
	);

	ffc_pack u_pack (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.valid_s2(valid_s2),
		.rnd_s2(rnd_s2),
		.valid_s3(valid_s3),
		.res_s3(res_s3)
	);

	assign m_axis_tvalid = valid_s3;
	assign m_axis_tdata = res_s3.result;

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s3 |-> s_axis_tready)
		else $error("input stalled with an empty output register");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> valid_s1)
		else $error("accepted transfer did not enter the first stage");

	a_narrow_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && (res_s3.cmd == CMD_S2H || res_s3.cmd == CMD_S2B))
			|-> (res_s3.result[31:16] == 16'd0))
		else $error("narrowed result has nonzero upper half");

	a_widen_low_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && (res_s3.cmd == CMD_H2S || res_s3.cmd == CMD_B2S))
			|-> (res_s3.result[12:0] == 13'd0))
		else $error("widened result has nonzero low fraction bits");

endmodule

[rtl/ffc_decode.sv]
module ffc_decode (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  ffc_pkg::cmd_t in_cmd,
	input  logic [ffc_pkg::OP_W-1:0] in_op,
	output logic valid_s1,
	output ffc_pkg::dec_t dec_s1
);
	import ffc_pkg::*;

	dec_t dec_d;
	logic [4:0] h_ex;
	logic [9:0] h_fr;
	logic [7:0] s_ex;
	logic s_fr_nz;
	logic [7:0] sh_full;

	always_comb begin
		h_ex = in_op[14:10];
		h_fr = in_op[9:0];
		s_ex = in_op[30:23];
		s_fr_nz = |in_op[22:0];
		sh_full = SUB_SHIFT_BASE - s_ex;

		dec_d.cmd = in_cmd;
		dec_d.op = in_op;

		// Leading-zero count of the half fraction; the highest set bit wins.
		dec_d.lz = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (h_fr[i]) begin
				dec_d.lz = 4'(9 - i);
			end
		end

		if (h_ex == 5'd0) begin
			dec_d.hclass = (h_fr == 10'd0) ? HC_ZERO : HC_SUB;
		end else if (h_ex == 5'h1f) begin
			dec_d.hclass = HC_SPECIAL;
		end else begin
			dec_d.hclass = HC_NORM;
		end

		dec_d.sh_m1 = SUB_SHIFT_MIN;
		if (s_ex == EXP32_ALL) begin
			dec_d.nclass = s_fr_nz ? NC_NAN : NC_INF;
		end else if (s_ex > HALF_OVF_EXP) begin
			dec_d.nclass = NC_INF;
		end else if (s_ex >= HALF_NORM_EXP) begin
			dec_d.nclass = NC_NORM;
		end else if (s_ex >= HALF_SUB_EXP) begin
			dec_d.nclass = NC_SUB;
			dec_d.sh_m1 = sh_full[4:0];
		end else begin
			dec_d.nclass = NC_ZERO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dec_s1 <= dec_d;
		end
	end

endmodule

[rtl/ffc_round.sv]
module ffc_round (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic valid_s1,
	input  ffc_pkg::dec_t dec_s1,
	output logic valid_s2,
	output ffc_pkg::rnd_t rnd_s2
);
	import ffc_pkg::*;

	rnd_t rnd_d;
	logic [31:0] op;
	logic [9:0] h_fr;
	logic [9:0] fn_sh;
	logic [7:0] w_exp;
	logic [22:0] s_fr;
	logic [23:0] sig;
	logic [23:0] sig_sh;
	logic [9:0] rf;
	logic [9:0] nan_fr;
	logic [4:0] re;
	logic guard;
	logic sticky;

	always_comb begin
		op = dec_s1.op;
		h_fr = op[9:0];
		fn_sh = h_fr << dec_s1.lz;
		w_exp = REBIAS - {4'd0, dec_s1.lz};
		s_fr = op[22:0];
		sig = {1'b1, s_fr};
		sig_sh = (sig >> dec_s1.sh_m1) >> 1;
		nan_fr = (s_fr[22:13] == 10'd0) ? 10'd1 : s_fr[22:13];
		re = 5'(op[30:23] - REBIAS);
		rf = 10'd0;
		guard = 1'b0;
		sticky = 1'b0;

		rnd_d.cmd = dec_s1.cmd;
		rnd_d.base = '0;
		rnd_d.inc = 1'b0;

		unique case (dec_s1.cmd)
			CMD_H2S: begin
				unique case (dec_s1.hclass)
					HC_ZERO: rnd_d.base = {op[15], 31'd0};
					HC_SUB: rnd_d.base = {op[15], w_exp, fn_sh[8:0], 1'b0, 13'd0};
					HC_SPECIAL: rnd_d.base = {op[15], EXP32_ALL, h_fr, 13'd0};
					HC_NORM: rnd_d.base = {op[15], {3'd0, op[14:10]} + REBIAS, h_fr, 13'd0};
					default: rnd_d.base = '0;
				endcase
			end
			CMD_S2H: begin
				unique case (dec_s1.nclass)
					NC_NAN: begin
						rnd_d.base = {16'd0, op[31] | EXP16_ALL[15], EXP16_ALL[14:10],
							nan_fr | QUIET16};
					end
					NC_INF: rnd_d.base = {16'd0, op[31], EXP16_ALL[14:0]};
					NC_NORM: begin
						rf = s_fr[22:13];
						guard = s_fr[12];
						sticky = |s_fr[11:0];
						rnd_d.base = {16'd0, op[31], re, rf};
					end
					NC_SUB: begin
						rf = sig_sh[9:0];
						guard = sig[dec_s1.sh_m1];
						sticky = |(sig & ((24'd1 << dec_s1.sh_m1) - 24'd1));
						rnd_d.base = {16'd0, op[31], 5'd0, rf};
					end
					NC_ZERO: rnd_d.base = {16'd0, op[31], 15'd0};
					default: rnd_d.base = '0;
				endcase
				rnd_d.inc = guard & (sticky | rf[0]);
			end
			CMD_B2S: rnd_d.base = {op[15:0], 16'd0};
			CMD_S2B: begin
				if (dec_s1.nclass == NC_NAN) begin
					rnd_d.base = {16'd0, op[31:16] | QUIET_BF};
				end else begin
					rnd_d.base = {16'd0, op[31:16]};
					rnd_d.inc = op[15] & ((|op[14:0]) | op[16]);
				end
			end
			default: rnd_d.base = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rnd_s2 <= rnd_d;
		end
	end

endmodule

[rtl/ffc_pack.sv]
module ffc_pack (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic valid_s2,
	input  ffc_pkg::rnd_t rnd_s2,
	output logic valid_s3,
	output ffc_pkg::res_t res_s3
);
	import ffc_pkg::*;

	res_t res_d;

	// The increment carries from fraction into exponent, which gives the
	// smallest normal or infinity exactly where rounding runs over.
	always_comb begin
		res_d.cmd = rnd_s2.cmd;
		res_d.result = {rnd_s2.base[31:16], rnd_s2.base[15:0] + {15'd0, rnd_s2.inc}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s3 <= res_d;
		end
	end

endmodule
